FILE: hdl/pcc_pkg.sv
// Shared types, constants and codes for the Pearson correlation core.
package pcc_pkg;

    localparam int SAMPLE_W         = 16;
    localparam int MAX_SAMPLES_DEF  = 65536;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int CNT_W            = 17;
    localparam int SUM_W            = 33;
    localparam int SQ_W             = 47;
    localparam int XP_W             = 48;
    localparam int WIDE_W           = 64;
    localparam int PROD_W           = 128;
    localparam int QUO_W            = 33;
    localparam int ROOT_W           = 34;
    localparam int CORR_W           = 16;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x_value;
        logic signed [SAMPLE_W-1:0] y_value;
        logic                       last_sample;
    } in_word_t;

    typedef struct packed {
        logic signed [CORR_W-1:0] corr_value;
        logic [1:0]               status;
    } out_word_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FEW  = 2'd1,
        STAT_FLAT = 2'd2,
        STAT_OVER = 2'd3
    } stat_t;

    // Product sequence of the finish phase
    typedef enum logic [2:0] {
        SEL_NXX  = 3'd0,
        SEL_SXSX = 3'd1,
        SEL_NYY  = 3'd2,
        SEL_SYSY = 3'd3,
        SEL_NXY  = 3'd4,
        SEL_SXSY = 3'd5,
        SEL_P    = 3'd6,
        SEL_SS   = 3'd7
    } mul_sel_t;

    typedef enum logic [3:0] {
        S_ACCUM,
        S_DRAIN,
        S_CHECK,
        S_MUL,
        S_SAVE,
        S_ZCHK,
        S_DIV,
        S_SQRT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic     accept;
        logic     clear;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     save;
        mul_sel_t save_sel;
        logic     div_start;
        logic     sqrt_start;
        logic     set_result;
        stat_t    result_code;
    } cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic overflow;
        logic few;
        logic flat;
        logic mul_busy;
        logic mul_done;
        logic div_done;
        logic sqrt_done;
    } sts_t;

endpackage

FILE: hdl/pcc_mul.sv
// Bit-serial 64x64 unsigned shift-add multiplier.
module pcc_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pcc_pkg::WIDE_W-1:0]    a,
    input  logic [pcc_pkg::WIDE_W-1:0]    b,
    output logic                          busy,
    output logic                          done,
    output logic [pcc_pkg::PROD_W-1:0]    prod
);

    localparam int W  = pcc_pkg::WIDE_W;
    localparam int CW = $clog2(W);

    logic [W-1:0]              a_reg;
    logic [pcc_pkg::PROD_W-1:0] prod_reg;
    logic [CW-1:0]             cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [W:0]                sum;

    assign sum = {1'b0, prod_reg[2*W-1:W]} + (prod_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= a;
            prod_reg <= {{W{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            prod_reg <= {sum, prod_reg[W-1:1]};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign prod = prod_reg;

endmodule

FILE: hdl/pcc_datapath.sv
// Accumulators, finish arithmetic (multiply, divide, root) and result registers.
module pcc_datapath #(
    parameter int MAX_SAMPLES  = pcc_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_WIDTH = pcc_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pcc_pkg::cmd_t      cmd,
    input  pcc_pkg::in_word_t  in_data,
    output pcc_pkg::sts_t      sts,
    output pcc_pkg::out_word_t out_data
);

    localparam int SH  = pcc_pkg::SAMPLE_W - SAMPLE_WIDTH;
    localparam int W   = pcc_pkg::WIDE_W;
    localparam int PW  = pcc_pkg::PROD_W;
    localparam int QW  = pcc_pkg::QUO_W;
    localparam int RW  = pcc_pkg::ROOT_W;
    localparam int KW  = RW / 2;
    localparam int DCW = $clog2(QW);
    localparam int SCW = $clog2(KW);

    // accumulation pipeline
    logic signed [pcc_pkg::SAMPLE_W-1:0] xs, ys, xa_reg, ya_reg;
    logic                                a_valid_reg, b_valid_reg;
    logic signed [2*pcc_pkg::SAMPLE_W-1:0] pxx_reg, pyy_reg, pxy_reg;
    logic [pcc_pkg::CNT_W-1:0]           count_reg;
    logic signed [pcc_pkg::SUM_W-1:0]    sum_x_reg, sum_y_reg;
    logic [pcc_pkg::SQ_W-1:0]            sum_xx_reg, sum_yy_reg;
    logic signed [pcc_pkg::XP_W-1:0]     sum_xy_reg;
    logic                                ov_reg;

    // finish
    logic [pcc_pkg::SUM_W-1:0] ax, ay;
    logic [pcc_pkg::XP_W-1:0]  axy;
    logic [W-1:0]              mul_a, mul_b, t_reg, sxx_reg, syy_reg, smag_reg;
    logic [W-1:0]              plo, signed_p, dif;
    logic                      neg_reg;
    logic                      mul_busy, mul_done;
    logic [PW-1:0]             prod, p_reg, s2_reg;

    logic [PW-1:0]             rem_reg, trial_rem;
    logic [QW-1:0]             quo_reg;
    logic [DCW-1:0]            dcnt_reg;
    logic                      div_busy_reg, div_done_reg, rem_ge;

    logic [RW-1:0]             op_reg, res_reg, one_reg, trial_sq;
    logic [SCW-1:0]            scnt_reg;
    logic                      sqrt_busy_reg, sqrt_done_reg;
    logic [KW:0]               kq;
    logic [pcc_pkg::CORR_W-1:0] corr_calc;

    logic [pcc_pkg::CORR_W-1:0] corr_reg;
    logic [1:0]                 status_reg;

    assign xs = (in_data.x_value <<< SH) >>> SH;
    assign ys = (in_data.y_value <<< SH) >>> SH;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            count_reg   <= '0;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            sum_xx_reg  <= '0;
            sum_yy_reg  <= '0;
            sum_xy_reg  <= '0;
            ov_reg      <= 1'b0;
        end
        else if (cmd.clear)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            count_reg   <= '0;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            sum_xx_reg  <= '0;
            sum_yy_reg  <= '0;
            sum_xy_reg  <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            a_valid_reg <= 1'b0;
            if (cmd.accept)
            begin
                if (count_reg == pcc_pkg::CNT_W'(MAX_SAMPLES))
                begin
                    ov_reg <= 1'b1;
                end
                else
                begin
                    a_valid_reg <= 1'b1;
                    count_reg   <= count_reg + 1'b1;
                    sum_x_reg   <= sum_x_reg + pcc_pkg::SUM_W'(xs);
                    sum_y_reg   <= sum_y_reg + pcc_pkg::SUM_W'(ys);
                end
            end
            b_valid_reg <= a_valid_reg;
            if (b_valid_reg)
            begin
                sum_xx_reg <= sum_xx_reg + pcc_pkg::SQ_W'($unsigned(pxx_reg));
                sum_yy_reg <= sum_yy_reg + pcc_pkg::SQ_W'($unsigned(pyy_reg));
                sum_xy_reg <= sum_xy_reg + pcc_pkg::XP_W'(pxy_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            xa_reg <= xs;
            ya_reg <= ys;
        end
        if (a_valid_reg)
        begin
            pxx_reg <= xa_reg * xa_reg;
            pyy_reg <= ya_reg * ya_reg;
            pxy_reg <= xa_reg * ya_reg;
        end
    end

    // magnitudes of the signed sums
    assign ax  = sum_x_reg[pcc_pkg::SUM_W-1] ? $unsigned(-sum_x_reg) : $unsigned(sum_x_reg);
    assign ay  = sum_y_reg[pcc_pkg::SUM_W-1] ? $unsigned(-sum_y_reg) : $unsigned(sum_y_reg);
    assign axy = sum_xy_reg[pcc_pkg::XP_W-1] ? $unsigned(-sum_xy_reg)
                                             : $unsigned(sum_xy_reg);

    always_comb
    begin
        case (cmd.mul_sel)
            pcc_pkg::SEL_NXX:  begin mul_a = W'(count_reg); mul_b = W'(sum_xx_reg); end
            pcc_pkg::SEL_SXSX: begin mul_a = W'(ax);        mul_b = W'(ax);         end
            pcc_pkg::SEL_NYY:  begin mul_a = W'(count_reg); mul_b = W'(sum_yy_reg); end
            pcc_pkg::SEL_SYSY: begin mul_a = W'(ay);        mul_b = W'(ay);         end
            pcc_pkg::SEL_NXY:  begin mul_a = W'(count_reg); mul_b = W'(axy);        end
            pcc_pkg::SEL_SXSY: begin mul_a = W'(ax);        mul_b = W'(ay);         end
            pcc_pkg::SEL_P:    begin mul_a = sxx_reg;       mul_b = syy_reg;        end
            default:           begin mul_a = smag_reg;      mul_b = smag_reg;       end
        endcase
    end

    pcc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .done  (mul_done),
        .prod  (prod)
    );

    // reapply the sign of the product that was formed from magnitudes
    assign plo = prod[W-1:0];
    always_comb
    begin
        if (cmd.save_sel == pcc_pkg::SEL_NXY)
            signed_p = sum_xy_reg[pcc_pkg::XP_W-1] ? -plo : plo;
        else
            signed_p = (sum_x_reg[pcc_pkg::SUM_W-1] ^ sum_y_reg[pcc_pkg::SUM_W-1]) ? -plo : plo;
    end
    assign dif = t_reg - signed_p;

    always_ff @(posedge clk)
    begin
        if (cmd.save)
        begin
            case (cmd.save_sel)
                pcc_pkg::SEL_NXX:  t_reg   <= plo;
                pcc_pkg::SEL_SXSX: sxx_reg <= t_reg - plo;
                pcc_pkg::SEL_NYY:  t_reg   <= plo;
                pcc_pkg::SEL_SYSY: syy_reg <= t_reg - plo;
                pcc_pkg::SEL_NXY:  t_reg   <= signed_p;
                pcc_pkg::SEL_SXSY:
                begin
                    neg_reg  <= dif[W-1];
                    smag_reg <= dif[W-1] ? -dif : dif;
                end
                pcc_pkg::SEL_P:    p_reg   <= prod;
                default:           s2_reg  <= prod;
            endcase
        end
    end

    // restoring divide: quo = floor((S^2 << 32) / P), one bit a cycle
    assign trial_rem = {rem_reg[PW-2:0], (dcnt_reg == '0) ? s2_reg[0] : 1'b0};
    assign rem_ge    = trial_rem >= p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
            dcnt_reg     <= '0;
        end
        else
        begin
            div_done_reg <= 1'b0;
            if (cmd.div_start)
            begin
                div_busy_reg <= 1'b1;
                dcnt_reg     <= '0;
            end
            else if (div_busy_reg)
            begin
                dcnt_reg <= dcnt_reg + 1'b1;
                if (dcnt_reg == DCW'(QW - 1))
                begin
                    div_busy_reg <= 1'b0;
                    div_done_reg <= 1'b1;
                end
            end
        end
    end

    // start loads straight from the multiplier: S^2 is saved on the same edge
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= {1'b0, prod[PW-1:1]};
            quo_reg <= '0;
        end
        else if (div_busy_reg)
        begin
            rem_reg <= rem_ge ? trial_rem - p_reg : trial_rem;
            quo_reg <= {quo_reg[QW-2:0], rem_ge};
        end
    end

    // digit-by-digit integer square root of the quotient
    assign trial_sq = res_reg + one_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sqrt_busy_reg <= 1'b0;
            sqrt_done_reg <= 1'b0;
            scnt_reg      <= '0;
        end
        else
        begin
            sqrt_done_reg <= 1'b0;
            if (cmd.sqrt_start)
            begin
                sqrt_busy_reg <= 1'b1;
                scnt_reg      <= '0;
            end
            else if (sqrt_busy_reg)
            begin
                scnt_reg <= scnt_reg + 1'b1;
                if (scnt_reg == SCW'(KW - 1))
                begin
                    sqrt_busy_reg <= 1'b0;
                    sqrt_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            op_reg  <= RW'(quo_reg);
            res_reg <= '0;
            one_reg <= RW'(1) << (RW - 2);
        end
        else if (sqrt_busy_reg)
        begin
            if (op_reg >= trial_sq)
            begin
                op_reg  <= op_reg - trial_sq;
                res_reg <= (res_reg >> 1) + one_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            one_reg <= one_reg >> 2;
        end
    end

    // largest odd t <= root gives k = (root + 1) / 2, at most 32768
    assign kq = ({1'b0, res_reg[KW-1:0]} + 1'b1) >> 1;

    always_comb
    begin
        if (neg_reg)
            corr_calc = -kq[pcc_pkg::CORR_W-1:0];
        else if (kq[pcc_pkg::CORR_W-1])
            corr_calc = {1'b0, {(pcc_pkg::CORR_W-1){1'b1}}};
        else
            corr_calc = kq[pcc_pkg::CORR_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_result)
        begin
            status_reg <= cmd.result_code;
            corr_reg   <= (cmd.result_code == pcc_pkg::STAT_OK) ? corr_calc : '0;
        end
    end

    assign sts.pipe_busy = a_valid_reg | b_valid_reg;
    assign sts.overflow  = ov_reg;
    assign sts.few       = count_reg < pcc_pkg::CNT_W'(2);
    assign sts.flat      = (sxx_reg == '0) || (syy_reg == '0);
    assign sts.mul_busy  = mul_busy;
    assign sts.mul_done  = mul_done;
    assign sts.div_done  = div_done_reg;
    assign sts.sqrt_done = sqrt_done_reg;

    assign out_data.corr_value = corr_reg;
    assign out_data.status     = status_reg;

endmodule

FILE: hdl/pcc_ctrl.sv
// Controller state machine: intake, finish sequencing and result handoff.
module pcc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_last,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  pcc_pkg::sts_t sts,
    output pcc_pkg::cmd_t cmd
);

    pcc_pkg::state_t   state_reg, state_next;
    pcc_pkg::mul_sel_t sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcc_pkg::S_ACCUM;
            sel_reg   <= pcc_pkg::SEL_NXX;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        sel_next        = sel_reg;
        in_ready        = 1'b0;
        out_valid       = 1'b0;
        cmd             = '0;
        cmd.save_sel    = sel_reg;
        cmd.result_code = pcc_pkg::STAT_OK;
        unique case (state_reg)
            pcc_pkg::S_ACCUM:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && in_last)
                    state_next = pcc_pkg::S_DRAIN;
            end
            pcc_pkg::S_DRAIN:
            begin
                if (!sts.pipe_busy)
                    state_next = pcc_pkg::S_CHECK;
            end
            pcc_pkg::S_CHECK:
            begin
                if (sts.overflow)
                begin
                    cmd.set_result  = 1'b1;
                    cmd.result_code = pcc_pkg::STAT_OVER;
                    state_next      = pcc_pkg::S_OUT;
                end
                else if (sts.few)
                begin
                    cmd.set_result  = 1'b1;
                    cmd.result_code = pcc_pkg::STAT_FEW;
                    state_next      = pcc_pkg::S_OUT;
                end
                else
                begin
                    sel_next      = pcc_pkg::SEL_NXX;
                    cmd.mul_start = 1'b1;
                    state_next    = pcc_pkg::S_MUL;
                end
            end
            pcc_pkg::S_MUL:
            begin
                if (sts.mul_done)
                    state_next = pcc_pkg::S_SAVE;
            end
            pcc_pkg::S_SAVE:
            begin
                cmd.save = 1'b1;
                if (sel_reg == pcc_pkg::SEL_SYSY)
                begin
                    state_next = pcc_pkg::S_ZCHK;
                end
                else if (sel_reg == pcc_pkg::SEL_SS)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = pcc_pkg::S_DIV;
                end
                else
                begin
                    sel_next      = pcc_pkg::mul_sel_t'(sel_reg + 3'd1);
                    cmd.mul_start = 1'b1;
                    state_next    = pcc_pkg::S_MUL;
                end
            end
            pcc_pkg::S_ZCHK:
            begin
                if (sts.flat)
                begin
                    cmd.set_result  = 1'b1;
                    cmd.result_code = pcc_pkg::STAT_FLAT;
                    state_next      = pcc_pkg::S_OUT;
                end
                else
                begin
                    sel_next      = pcc_pkg::SEL_NXY;
                    cmd.mul_start = 1'b1;
                    state_next    = pcc_pkg::S_MUL;
                end
            end
            pcc_pkg::S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = pcc_pkg::S_SQRT;
                end
            end
            pcc_pkg::S_SQRT:
            begin
                if (sts.sqrt_done)
                begin
                    cmd.set_result  = 1'b1;
                    cmd.result_code = pcc_pkg::STAT_OK;
                    state_next      = pcc_pkg::S_OUT;
                end
            end
            pcc_pkg::S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.clear  = 1'b1;
                    state_next = pcc_pkg::S_ACCUM;
                end
            end
            default:
            begin
                state_next = pcc_pkg::S_ACCUM;
            end
        endcase
        cmd.mul_sel = sel_next;
    end

`ifndef SYNTHESIS
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pcc_pkg::S_OUT && !out_ready) |=> (state_reg == pcc_pkg::S_OUT))
        else $error("result word dropped before it was taken");

    a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |-> !sts.mul_busy)
        else $error("multiplier restarted while busy");

    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pcc_pkg::S_CHECK) |-> !sts.pipe_busy)
        else $error("finish began with accumulation still in flight");
`endif

endmodule

FILE: hdl/pearson_correlation_core.sv
// Top level of the streaming Pearson correlation core.
//
//  channel | dir | handshake            | word
//  --------+-----+----------------------+------------------------------------
//  in      | in  | in_valid / in_ready  | in_data: x_value, y_value, last_sample
//  out     | out | out_valid / out_ready| out_data: corr_value (Q1.15), status
//
// Cycles: pairs are taken one per cycle while accumulating (three-stage
//   pipeline: register, square/cross products, add to the sums).
// A word marked last ends the set; intake stops and the result is built
//   through drain and check, the bit-serial 64x64 multiplier used eight
//   times (with the zero-spread check after the fourth product), the
//   33-step divider and the 17-step square root.
// Error cases (too many samples, fewer than two) finish straight after the check.
// Reset: rst_n clears all sums, counters and the controller at once.
// Stalls: the result word holds in its register until out_ready; intake
//   resumes the cycle after it is taken.
module pearson_correlation_core #(
    parameter int MAX_SAMPLES  = pcc_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_WIDTH = pcc_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pcc_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output pcc_pkg::out_word_t out_data
);

    pcc_pkg::cmd_t cmd;
    pcc_pkg::sts_t sts;

    // sequencing: intake, finish steps, result handoff
    pcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (in_data.last_sample),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // sums, shared multiplier, divider, root and result register
    pcc_datapath #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .sts      (sts),
        .out_data (out_data)
    );

endmodule
